// ===== rtl/cpe_pkg.sv =====
package cpe_pkg;

  localparam int LANE_LAT = 97;
  localparam int SERIES_TERMS = 14;

  localparam logic [29:0] LOG2E_Q29 = 30'd774541002;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] RECIP_REM0 = 31'h2000_0000;
  localparam logic [30:0] HEIGHT_RST = 31'd65536;

  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LEFT   = 2'd2,
    REG_RIGHT  = 2'd3
  } cfg_reg_e;

  // Hyperbolic pair of one lane: cosh = s * 2^(n-31), sinh = d * 2^(n-31).
  typedef struct packed {
    logic        ovf;
    logic [5:0]  n;
    logic [31:0] s;
    logic [30:0] d;
  } hyp_t;

endpackage

// ===== rtl/cpe_div_cell.sv =====
module cpe_div_cell import cpe_pkg::*; #(
  parameter int QW = 33,
  parameter int PW = 36
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [30:0]   rem_i,
  input  logic [30:0]   den_i,
  input  logic          bit_i,
  input  logic [QW-1:0] quo_i,
  input  logic [PW-1:0] pay_i,
  output logic [30:0]   rem_o,
  output logic [30:0]   den_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic [31:0]   trial;
  logic          ge;
  logic [30:0]   rem_d;
  logic [30:0]   rem_q;
  logic [30:0]   den_q;
  logic [QW-1:0] quo_q;
  logic [PW-1:0] pay_q;

  always_comb begin
    trial = {rem_i, bit_i};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? 31'(trial - {1'b0, den_i}) : trial[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= {quo_i[QW-2:0], ge};
      pay_q <= pay_i;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;
  assign pay_o = pay_q;

endmodule

// ===== rtl/cpe_series_cell.sv =====
module cpe_series_cell import cpe_pkg::*; #(
  parameter int DIV = 1
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] term_i,
  input  logic [30:0] sum_i,
  input  logic [29:0] y_i,
  input  logic [6:0]  pay_i,
  output logic [30:0] term_o,
  output logic [30:0] sum_o,
  output logic [29:0] y_o,
  output logic [6:0]  pay_o
);

  // The reciprocal is exact for every dividend below 2^30.
  localparam logic [34:0] RECIP = 35'(((64'd1 << 34) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [60:0] prod1;
  logic [65:0] prod2;
  logic [30:0] v_q;
  logic [30:0] sum1_q;
  logic [29:0] y1_q;
  logic [6:0]  pay1_q;
  logic [30:0] term2_q;
  logic [30:0] sum2_q;
  logic [29:0] y2_q;
  logic [6:0]  pay2_q;

  assign prod1 = 61'(term_i) * 61'(y_i);
  assign prod2 = 66'(v_q) * 66'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q     <= prod1[60:30];
      sum1_q  <= sum_i + term_i;
      y1_q    <= y_i;
      pay1_q  <= pay_i;
      term2_q <= prod2[64:34];
      sum2_q  <= sum1_q;
      y2_q    <= y1_q;
      pay2_q  <= pay1_q;
    end
  end

  assign term_o = term2_q;
  assign sum_o  = sum2_q;
  assign y_o    = y2_q;
  assign pay_o  = pay2_q;

endmodule

// ===== rtl/cpe_hyp_lane.sv =====
module cpe_hyp_lane import cpe_pkg::*; #(
  parameter int SHIFT = 28
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [34:0] mag_i,
  input  logic [30:0] den_i,
  output hyp_t        res_o
);

  localparam int PRE = 33 - SHIFT;

  logic [34:0] pre_sh;
  logic        ovf0_q;
  logic [30:0] rem0_q;
  logic [30:0] den0_q;
  logic [34:0] mag0_q;

  logic [30:0] rrem_w [34];
  logic [30:0] rden_w [34];
  logic [32:0] rquo_w [34];
  logic [35:0] rpay_w [34];

  logic [62:0] wprod;
  logic [33:0] w_q;
  logic        wovf_q;
  logic [57:0] yprod;
  logic [29:0] y_q;
  logic [6:0]  ypay_q;

  logic [30:0] sterm_w [SERIES_TERMS+1];
  logic [30:0] ssum_w [SERIES_TERMS+1];
  logic [29:0] sy_w [SERIES_TERMS+1];
  logic [6:0]  spay_w [SERIES_TERMS+1];

  logic [30:0] e_q;
  logic [6:0]  epay_q;

  logic [30:0] crem_w [32];
  logic [30:0] cden_w [32];
  logic [30:0] cquo_w [32];
  logic [6:0]  cpay_w [32];

  logic [30:0] t_val;
  hyp_t        res_q;

  assign pre_sh = mag_i >> PRE;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf0_q <= pre_sh >= {4'b0, den_i};
      rem0_q <= pre_sh[30:0];
      den0_q <= den_i;
      mag0_q <= mag_i;
    end
  end

  assign rrem_w[0] = rem0_q;
  assign rden_w[0] = den0_q;
  assign rquo_w[0] = '0;
  assign rpay_w[0] = {ovf0_q, mag0_q};

  for (genvar g = 0; g < 33; g++) begin : g_ratio
    localparam int J = 32 - g;
    logic dbit;
    if (J >= SHIFT) begin : g_bit
      assign dbit = rpay_w[g][J-SHIFT];
    end else begin : g_zero
      assign dbit = 1'b0;
    end
    cpe_div_cell #(.QW(33), .PW(36)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rrem_w[g]),
      .den_i (rden_w[g]),
      .bit_i (dbit),
      .quo_i (rquo_w[g]),
      .pay_i (rpay_w[g]),
      .rem_o (rrem_w[g+1]),
      .den_o (rden_w[g+1]),
      .quo_o (rquo_w[g+1]),
      .pay_o (rpay_w[g+1])
    );
  end

  assign wprod = 63'(rquo_w[33]) * 63'(LOG2E_Q29);
  assign yprod = 58'(w_q[27:0]) * 58'(LN2_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q    <= wprod[62:29];
      wovf_q <= rpay_w[33][35];
      y_q    <= yprod[57:28];
      ypay_q <= {wovf_q, w_q[33:28]};
    end
  end

  assign sterm_w[0] = ONE_Q30;
  assign ssum_w[0]  = '0;
  assign sy_w[0]    = y_q;
  assign spay_w[0]  = ypay_q;

  for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_series
    cpe_series_cell #(.DIV(g + 1)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .term_i (sterm_w[g]),
      .sum_i  (ssum_w[g]),
      .y_i    (sy_w[g]),
      .pay_i  (spay_w[g]),
      .term_o (sterm_w[g+1]),
      .sum_o  (ssum_w[g+1]),
      .y_o    (sy_w[g+1]),
      .pay_o  (spay_w[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= ssum_w[SERIES_TERMS] + sterm_w[SERIES_TERMS];
      epay_q <= spay_w[SERIES_TERMS];
    end
  end

  assign crem_w[0] = RECIP_REM0;
  assign cden_w[0] = e_q;
  assign cquo_w[0] = '0;
  assign cpay_w[0] = epay_q;

  for (genvar g = 0; g < 31; g++) begin : g_recip
    cpe_div_cell #(.QW(31), .PW(7)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (crem_w[g]),
      .den_i (cden_w[g]),
      .bit_i (1'b0),
      .quo_i (cquo_w[g]),
      .pay_i (cpay_w[g]),
      .rem_o (crem_w[g+1]),
      .den_o (cden_w[g+1]),
      .quo_o (cquo_w[g+1]),
      .pay_o (cpay_w[g+1])
    );
  end

  assign t_val = cquo_w[31] >> {cpay_w[31][5:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.ovf <= cpay_w[31][6];
      res_q.n   <= cpay_w[31][5:0];
      res_q.s   <= {1'b0, cden_w[31]} + {1'b0, t_val};
      res_q.d   <= cden_w[31] - t_val;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/catenary_point_evaluator_top.sv =====
// Catenary point evaluator.
// Input stream: s_axis_tdata carries x (signed Q16.16), s_axis_tuser[0] asks
// that the height also be checked against the limits. Each transaction yields
// one output transaction with height, radius of curvature and arc length
// (unsigned Q15.16, saturated) in m_axis_tdata and the out-of-range and overflow
// flags in m_axis_tuser.
// The configuration port writes offset, parameter a and the two limits; write
// it only while no transaction is in flight.
// A transaction passes one front stage, 97 stages per hyperbolic lane (an input
// stage, a 33-cell divider for the ratio, two multiplier stages, a 28-stage
// series for exp, a summing stage, a 31-cell reciprocal divider and a final
// stage), four product and scaling stages and the output register. Three lanes
// run side by side, taking one transaction per cycle while s_axis_tready is high.
// The pipeline moves as a whole. A skid register behind the output register
// takes one more result while the receiver stalls; only when it is full does
// s_axis_tready drop.
// Reset clears all valid bits and loads the register defaults (offset 0,
// a = 1.0, both limits 0).
module catenary_point_evaluator_top import cpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_coord
  input  logic [0:0]  s_axis_tuser,   // check_range
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // height, curvature_radius, arc_length, zero fill
  output logic [1:0]  m_axis_tuser,   // out_of_range, overflowed
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef struct packed {
    logic [30:0] a;
    logic        chk;
    logic        outside;
    logic        rev;
    logic        eq;
  } sb_t;

  typedef struct packed {
    logic [30:0] height;
    logic [30:0] radius;
    logic [30:0] arc;
    logic        outside;
    logic        sat;
  } res_t;

  function automatic logic [31:0] scale_fn(input logic [94:0] p,
                                           input logic signed [7:0] rs);
    logic [94:0] v;
    v = p >> rs[6:0];
    if (p == '0) return '0;
    if (rs < 0) return {1'b1, OUT_MAX};
    if (v > 95'(OUT_MAX)) return {1'b1, OUT_MAX};
    return {1'b0, v[30:0]};
  endfunction

  logic [31:0] offset_q;
  logic [30:0] height_q;
  logic [31:0] left_q;
  logic [31:0] right_q;

  logic        en;
  logic        f_vld_q;
  sb_t         f_sb_q;
  logic [34:0] f_magp_q;
  logic [34:0] f_magm_q;
  logic [34:0] f_magh_q;

  logic signed [32:0] num_p;
  logic signed [34:0] num_m;
  logic signed [32:0] num_h;
  logic [30:0]        a_eff;

  logic [LANE_LAT-1:0] vld_q;
  sb_t                 sb_q [LANE_LAT];
  hyp_t                hp;
  hyp_t                hm;
  hyp_t                hh;

  logic               p_vld_q;
  sb_t                p_sb_q;
  logic               p_ovf_q;
  logic               p_arcovf_q;
  logic [62:0]        p_ph_q;
  logic [63:0]        p_s2_q;
  logic [62:0]        p_smdh_q;
  logic signed [7:0]  p_rsh_q;
  logic signed [7:0]  p_rsr_q;
  logic signed [7:0]  p_rsa_q;

  logic               q_vld_q;
  sb_t                q_sb_q;
  logic               q_ovf_q;
  logic               q_arcovf_q;
  logic [62:0]        q_ph_q;
  logic [62:0]        q_rlo_q;
  logic [62:0]        q_rhi_q;
  logic [62:0]        q_alo_q;
  logic [61:0]        q_ahi_q;
  logic signed [7:0]  q_rsh_q;
  logic signed [7:0]  q_rsr_q;
  logic signed [7:0]  q_rsa_q;

  logic               r_vld_q;
  sb_t                r_sb_q;
  logic               r_ovf_q;
  logic               r_arcovf_q;
  logic [62:0]        r_ph_q;
  logic [94:0]        r_p2_q;
  logic [94:0]        r_p3_q;
  logic signed [7:0]  r_rsh_q;
  logic signed [7:0]  r_rsr_q;
  logic signed [7:0]  r_rsa_q;

  logic [31:0] h_sc;
  logic [31:0] r_sc;
  logic [31:0] a_sc;
  logic        h_cut;
  res_t        s_d;
  logic        s_vld_q;
  res_t        s_q;

  logic out_vld_q;
  logic out_vld_d;
  res_t out_q;
  res_t out_d;
  logic skid_vld_q;
  logic skid_vld_d;
  res_t skid_q;
  res_t skid_d;
  logic push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      height_q <= HEIGHT_RST;
      left_q   <= '0;
      right_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OFFSET: offset_q <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i[30:0];
        REG_LEFT:   left_q   <= cfg_wdata_i;
        REG_RIGHT:  right_q  <= cfg_wdata_i;
        default:    offset_q <= offset_q;
      endcase
    end
  end

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_comb begin
    num_p = $signed({s_axis_tdata[31], s_axis_tdata}) + $signed({offset_q[31], offset_q});
    num_m = $signed({{3{right_q[31]}}, right_q}) + $signed({{3{left_q[31]}}, left_q})
          + $signed({{2{offset_q[31]}}, offset_q, 1'b0});
    num_h = $signed({right_q[31], right_q}) - $signed({left_q[31], left_q});
    a_eff = (height_q == '0) ? 31'd1 : height_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_magp_q       <= {2'b0, num_p[32] ? 33'(-num_p) : 33'(num_p)};
      f_magm_q       <= num_m[34] ? 35'(-num_m) : 35'(num_m);
      f_magh_q       <= {2'b0, 33'(num_h)};
      f_sb_q.a       <= a_eff;
      f_sb_q.chk     <= s_axis_tuser[0];
      f_sb_q.outside <= ($signed(s_axis_tdata) < $signed(left_q))
                     || ($signed(s_axis_tdata) > $signed(right_q));
      f_sb_q.rev     <= $signed(right_q) < $signed(left_q);
      f_sb_q.eq      <= right_q == left_q;
    end
  end

  cpe_hyp_lane #(.SHIFT(28)) u_lane_point (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (f_magp_q),
    .den_i (f_sb_q.a),
    .res_o (hp)
  );

  cpe_hyp_lane #(.SHIFT(27)) u_lane_mid (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (f_magm_q),
    .den_i (f_sb_q.a),
    .res_o (hm)
  );

  cpe_hyp_lane #(.SHIFT(27)) u_lane_half (
    .clk_i (clk_i),
    .en_i  (en),
    .mag_i (f_magh_q),
    .den_i (f_sb_q.a),
    .res_o (hh)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      p_vld_q <= 1'b0;
      q_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[LANE_LAT-2:0], f_vld_q};
      p_vld_q <= vld_q[LANE_LAT-1];
      q_vld_q <= p_vld_q;
      r_vld_q <= q_vld_q;
      s_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= f_sb_q;
      for (int i = 1; i < LANE_LAT; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sb_q     <= sb_q[LANE_LAT-1];
      p_ovf_q    <= hp.ovf;
      p_arcovf_q <= hm.ovf | hh.ovf;
      p_ph_q     <= 63'(sb_q[LANE_LAT-1].a) * 63'(hp.s);
      p_s2_q     <= 64'(hp.s) * 64'(hp.s);
      p_smdh_q   <= 63'(hm.s) * 63'(hh.d);
      p_rsh_q    <= 8'sd31 - $signed({2'b0, hp.n});
      p_rsr_q    <= 8'sd62 - $signed({1'b0, hp.n, 1'b0});
      p_rsa_q    <= 8'sd61 - $signed({2'b0, hm.n}) - $signed({2'b0, hh.n});

      q_sb_q     <= p_sb_q;
      q_ovf_q    <= p_ovf_q;
      q_arcovf_q <= p_arcovf_q;
      q_ph_q     <= p_ph_q;
      q_rlo_q    <= 63'(p_sb_q.a) * 63'(p_s2_q[31:0]);
      q_rhi_q    <= 63'(p_sb_q.a) * 63'(p_s2_q[63:32]);
      q_alo_q    <= 63'(p_sb_q.a) * 63'(p_smdh_q[31:0]);
      q_ahi_q    <= 62'(p_sb_q.a) * 62'(p_smdh_q[62:32]);
      q_rsh_q    <= p_rsh_q;
      q_rsr_q    <= p_rsr_q;
      q_rsa_q    <= p_rsa_q;

      r_sb_q     <= q_sb_q;
      r_ovf_q    <= q_ovf_q;
      r_arcovf_q <= q_arcovf_q;
      r_ph_q     <= q_ph_q;
      r_p2_q     <= 95'(q_rlo_q) + {q_rhi_q, 32'b0};
      r_p3_q     <= 95'(q_alo_q) + {1'b0, q_ahi_q, 32'b0};
      r_rsh_q    <= q_rsh_q;
      r_rsr_q    <= q_rsr_q;
      r_rsa_q    <= q_rsa_q;

      s_q        <= s_d;
    end
  end

  always_comb begin
    h_sc  = scale_fn(95'(r_ph_q), r_rsh_q);
    r_sc  = scale_fn(r_p2_q, r_rsr_q);
    a_sc  = scale_fn(r_p3_q, r_rsa_q);
    h_cut = r_sb_q.chk && r_sb_q.outside;
    s_d   = '0;
    s_d.outside = r_sb_q.outside;
    if (r_ovf_q) begin
      s_d.height = h_cut ? '0 : OUT_MAX;
      s_d.radius = r_sb_q.outside ? '0 : OUT_MAX;
      s_d.sat    = !h_cut || !r_sb_q.outside;
    end else begin
      s_d.height = h_cut ? '0 : h_sc[30:0];
      s_d.radius = r_sb_q.outside ? '0 : r_sc[30:0];
      s_d.sat    = (!h_cut && h_sc[31]) || (!r_sb_q.outside && r_sc[31]);
    end
    priority if (r_sb_q.rev) begin
      s_d.sat = 1'b1;
    end else if (r_sb_q.eq) begin
      s_d.arc = '0;
    end else if (r_arcovf_q) begin
      s_d.arc = OUT_MAX;
      s_d.sat = 1'b1;
    end else begin
      s_d.arc = a_sc[30:0];
      s_d.sat = s_d.sat || a_sc[31];
    end
  end

  assign push = en && s_vld_q;

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || m_axis_tready) begin
        out_d     = s_q;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = s_q;
        skid_vld_d = 1'b1;
      end
    end else begin
      out_vld_d = out_vld_q && !m_axis_tready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b0, out_q.arc, out_q.radius, out_q.height};
  assign m_axis_tuser  = {out_q.sat, out_q.outside};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output is empty");

  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_vld_q && !m_axis_tready) |=> skid_vld_q)
    else $error("result arriving at a stalled output was not kept");

  a_radius_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[61:31] == '0))
    else $error("radius not zero for an x outside the limits");

  a_rev_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_vld_q && r_vld_q && en && r_sb_q.rev) |=> s_q.sat && (s_q.arc == '0))
    else $error("reversed limits did not give a flagged zero arc length");

endmodule
